// ===== rtl/battery_voltage_gauge_core_defines.svh =====
// ----------------------------------------------------------------------------
// battery voltage gauge assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_GAUGE_CORE_DEFINES_SVH
`define BATTERY_VOLTAGE_GAUGE_CORE_DEFINES_SVH

// condition holds at every edge
`define BVG_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle
`define BVG_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define BVG_IMPLY_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bvg_pkg.sv =====
// ----------------------------------------------------------------------------
// bvg_pkg
// Types and fixed constants of the battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

  localparam int MV_W      = 13;
  localparam int PCT_W     = 7;
  localparam int SEC_W     = 6;
  localparam int SLEW_W    = 8;
  localparam int WORD_W    = 48;
  localparam int ENTRY_W   = 16;
  localparam int WORDS     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int ALU_W     = 20;

  localparam logic [MV_W-1:0]   MV_MAX     = 13'h1FFF;
  localparam logic [PCT_W-1:0]  PCT_FULL   = 7'd100;
  localparam logic [SLEW_W-1:0] SLEW_RESET = 8'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW    = 3'd4;

  // input item
  typedef struct packed {
    logic              command;
    logic [MV_W-1:0]   voltage_mv;
    logic              restart;
    logic [SEC_W-1:0]  second_now;
    logic              charger_present;
    logic              charge_full;
  } item_t;

  // result item
  typedef struct packed {
    logic [MV_W-1:0]  reported_mv;
    logic [PCT_W-1:0] percent_level;
    logic [MV_W-1:0]  tracked_mv;
  } result_t;

  // shared subtractor result
  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             borrow;
  } alu_res_t;

endpackage

// ===== rtl/bvg_alu.sv =====
// ----------------------------------------------------------------------------
// bvg_alu
// Shared subtract and compare unit used by the report, tick, search and divide steps of the sequencer.
// ----------------------------------------------------------------------------
module bvg_alu (
  input  logic [bvg_pkg::ALU_W-1:0] a,
  input  logic [bvg_pkg::ALU_W-1:0] b,
  output bvg_pkg::alu_res_t         res
);
  import bvg_pkg::*;

  logic [ALU_W:0] full_diff;

  // a - b with borrow out, borrow set when a < b
  assign full_diff  = {1'b0, a} - {1'b0, b};
  assign res.diff   = full_diff[ALU_W-1:0];
  assign res.borrow = full_diff[ALU_W];

endmodule

// ===== rtl/battery_voltage_gauge_core.sv =====
// ----------------------------------------------------------------------------
// battery_voltage_gauge_core
// Voltage-lookup fuel gauge: averaged and reported voltage, slew-limited
// tracking and table interpolated percent, sequenced over one subtractor.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  item     | item_valid/item_ready  | item (command, voltage, tick fields)
//  result   | result_valid/ready     | result (reported, percent, tracked)
//  cfg      | cfg_valid/cfg_ready    | cfg_index, cfg_data (always ready)
//
//  a sample runs the sample, report and finish steps; an idle tick goes from tick
//  to finish; a tick with a lookup runs a table search that reads one entry a
//  cycle, then a 4-step restoring divide on the subtractor
//  item_ready is high only while the sequencer is idle; a waiting result does
//  not block acceptance but holds the next result in its final step
//  synchronous reset, no clearing pass
// ----------------------------------------------------------------------------
`include "battery_voltage_gauge_core_defines.svh"

module battery_voltage_gauge_core #(
  parameter int AVG_SHIFT     = 5,
  parameter int TABLE_ENTRIES = 11
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  bvg_pkg::item_t                       item,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output bvg_pkg::result_t                     result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bvg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bvg_pkg::WORD_W-1:0]           cfg_data
);
  import bvg_pkg::*;

  localparam int TW = MV_W + AVG_SHIFT;
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] TOP = IW'(TABLE_ENTRIES - 1);
  localparam logic [IW-1:0] FIRST = IW'(1);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_SAMPLE  = 10'b00_0000_0010,
    ST_REPORT  = 10'b00_0000_0100,
    ST_TICK    = 10'b00_0000_1000,
    ST_LOOK    = 10'b00_0001_0000,
    ST_SEARCH  = 10'b00_0010_0000,
    ST_LOAD_LO = 10'b00_0100_0000,
    ST_SCALE   = 10'b00_1000_0000,
    ST_DIVIDE  = 10'b01_0000_0000,
    ST_FINISH  = 10'b10_0000_0000
  } state_t;

  state_t state;

  // configuration
  logic [WORD_W-1:0]  table_word [WORDS];
  logic [SLEW_W-1:0]  slew_step;
  logic [ENTRY_W-1:0] entry [TABLE_ENTRIES];

  // gauge state
  logic [TW-1:0]    running_total;
  logic [MV_W-1:0]  average_mv;
  logic [MV_W-1:0]  reported_value;
  logic [MV_W-1:0]  tracked_value;
  logic [PCT_W-1:0] percent_value;

  // working registers
  item_t              item_r;
  logic [MV_W-1:0]    look_mv;
  logic [IW-1:0]      idx;
  logic [ENTRY_W-1:0] hi_mv;
  logic [MV_W-1:0]    num;
  logic [ENTRY_W-1:0] den;
  logic [7:0]         base_pct;
  logic [16:0]        rem;
  logic [3:0]         quot;
  logic [1:0]         div_bit;

  // combinational helpers
  logic [TW-1:0]      seed_total;
  logic [MV_W-1:0]    seed_avg;
  logic [TW-1:0]      total_next;
  logic [MV_W-1:0]    avg_next;
  logic               hyst_move;
  logic [ENTRY_W-1:0] top_entry;
  logic [ENTRY_W-1:0] target;
  logic [MV_W:0]      rise_sum;
  logic [MV_W-1:0]    slew_next;
  logic [IW-1:0]      rd_idx;
  logic [ENTRY_W-1:0] rd_entry;
  logic [IW-1:0]      idx_m1;
  logic [7:0]         base_next;
  logic               degenerate;
  logic [3:0]         quot_next;
  logic [7:0]         pct_sum;
  logic [ALU_W-1:0]   alu_a;
  logic [ALU_W-1:0]   alu_b;
  alu_res_t           alu;

  function automatic logic [PCT_W-1:0] pct_clip(input logic [7:0] p);
    pct_clip = (p > 8'(PCT_FULL)) ? PCT_FULL : p[PCT_W-1:0];
  endfunction

  function automatic logic is_step_second(input logic [SEC_W-1:0] s);
    case (s) inside
      6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30, 6'd35, 6'd40, 6'd45, 6'd50,
      6'd55, 6'd60: is_step_second = 1'b1;
      default:      is_step_second = 1'b0;
    endcase
  endfunction

  // table entries unpacked from the four words
  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_entry
    assign entry[k] = table_word[k / 3][16 * (k % 3) +: ENTRY_W];
  end

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < WORDS; w++) begin
        table_word[w] <= '0;
      end
      slew_step <= SLEW_RESET;
    end else if (cfg_valid) begin
      case (cfg_index) inside
        REG_TABLE_A, REG_TABLE_B, REG_TABLE_C, REG_TABLE_D: begin
          table_word[cfg_index[1:0]] <= cfg_data;
        end
        REG_SLEW: begin
          slew_step <= cfg_data[SLEW_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // running average step
  always_comb begin
    seed_total = item_r.restart ? {item_r.voltage_mv, {AVG_SHIFT{1'b0}}} : running_total;
    seed_avg   = item_r.restart ? item_r.voltage_mv : average_mv;
    total_next = seed_total - TW'(seed_avg) + TW'(item_r.voltage_mv);
    avg_next   = total_next[TW-1 -: MV_W];
  end

  // slew target and step
  always_comb begin
    top_entry = entry[TOP];
    target    = ENTRY_W'(average_mv);
    if (item_r.charger_present && item_r.charge_full && (ENTRY_W'(average_mv) < top_entry)) begin
      target = top_entry;
    end
    rise_sum  = {1'b0, tracked_value} + (MV_W + 1)'({slew_step, 2'b00});
    slew_next = tracked_value;
    if (item_r.charger_present) begin
      if (alu.borrow) begin
        slew_next = rise_sum[MV_W] ? MV_MAX : rise_sum[MV_W-1:0];
      end
    end else if (!alu.borrow && (alu.diff != '0)) begin
      slew_next = (tracked_value > MV_W'(slew_step)) ? tracked_value - MV_W'(slew_step) : '0;
    end
  end

  // table read port and interval setup
  always_comb begin
    rd_idx     = (state == ST_LOAD_LO) ? idx - FIRST : idx;
    rd_entry   = entry[rd_idx];
    idx_m1     = idx - FIRST;
    base_next  = 8'({idx_m1, 3'b000}) + 8'({idx_m1, 1'b0});
    degenerate = (hi_mv <= rd_entry) || (ENTRY_W'(look_mv) < rd_entry);
    quot_next  = quot;
    if (!alu.borrow) begin
      quot_next[div_bit] = 1'b1;
    end
    pct_sum    = base_pct + 8'(quot_next);
  end

  // hysteresis: |average - reported| >= 2
  assign hyst_move = alu.borrow ? (alu.diff != '1) : (alu.diff[ALU_W-1:1] != '0);

  // shared subtractor operand select
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state)
      ST_REPORT: begin
        alu_a = ALU_W'(average_mv);
        alu_b = ALU_W'(reported_value);
      end
      ST_TICK: begin
        alu_a = ALU_W'(tracked_value);
        alu_b = ALU_W'(target);
      end
      ST_SEARCH: begin
        alu_a = ALU_W'(look_mv);
        alu_b = ALU_W'(rd_entry);
      end
      ST_DIVIDE: begin
        alu_a = ALU_W'(rem);
        alu_b = ALU_W'(den) << div_bit;
      end
      default: ;
    endcase
  end

  bvg_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu)
  );

  assign item_ready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      running_total  <= '0;
      average_mv     <= '0;
      reported_value <= '0;
      tracked_value  <= '0;
      percent_value  <= '0;
      result_valid   <= 1'b0;
    end else begin
      // result drained; the final step reloads it on its own
      if (result_valid && result_ready && (state != ST_FINISH)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            item_r <= item;
            state  <= item.command ? ST_TICK : ST_SAMPLE;
          end
        end
        ST_SAMPLE: begin
          running_total <= total_next;
          average_mv    <= avg_next;
          if (item_r.restart) begin
            reported_value <= '0;
          end
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          if (hyst_move) begin
            reported_value <= average_mv;
          end
          state <= ST_FINISH;
        end
        ST_TICK: begin
          if (tracked_value == '0) begin
            tracked_value <= average_mv;
            look_mv       <= average_mv;
            state         <= ST_LOOK;
          end else if (!is_step_second(item_r.second_now)) begin
            state <= ST_FINISH;
          end else begin
            tracked_value <= slew_next;
            look_mv       <= slew_next;
            state         <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (ENTRY_W'(look_mv) >= entry[TOP]) begin
            percent_value <= PCT_FULL;
            state         <= ST_FINISH;
          end else if (ENTRY_W'(look_mv) <= entry[0]) begin
            percent_value <= '0;
            state         <= ST_FINISH;
          end else begin
            idx   <= FIRST;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          // first entry above the voltage, or the top one
          if (alu.borrow || (idx == TOP)) begin
            hi_mv <= rd_entry;
            state <= ST_LOAD_LO;
          end else begin
            idx <= idx + FIRST;
          end
        end
        ST_LOAD_LO: begin
          base_pct <= base_next;
          num      <= look_mv - rd_entry[MV_W-1:0];
          den      <= hi_mv - rd_entry;
          if (degenerate) begin
            percent_value <= pct_clip(base_next);
            state         <= ST_FINISH;
          end else begin
            state <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          // times ten as two shifted adds
          rem     <= 17'({num, 3'b000}) + 17'({num, 1'b0});
          quot    <= '0;
          div_bit <= 2'd3;
          state   <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (!alu.borrow) begin
            rem <= alu.diff[16:0];
          end
          quot <= quot_next;
          if (div_bit == 2'd0) begin
            percent_value <= pct_clip(pct_sum);
            state         <= ST_FINISH;
          end else begin
            div_bit <= div_bit - 2'd1;
          end
        end
        ST_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid         <= 1'b1;
            result.reported_mv   <= reported_value;
            result.percent_level <= percent_value;
            result.tracked_mv    <= tracked_value;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // assertions
  `BVG_IMPLY_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "accepted while busy")
  `BVG_CHECK(a_percent_range, percent_value <= PCT_FULL, "percent above full scale")
  `BVG_IMPLY(a_divide_span, state == ST_DIVIDE, den != '0, "divide with zero span")
  `BVG_IMPLY(a_load_from_finish, $rose(result_valid), $past(state == ST_FINISH), "stray result")

endmodule
